FILE: design/tlp_pkg.sv
// tlp_pkg: shared types, codes and constants of the timing line parser
// no dependencies; imported by every module of the block but tlp_line_mem
package tlp_pkg;

    localparam logic [1:0] EV_ECHO  = 2'd0;
    localparam logic [1:0] EV_START = 2'd1;
    localparam logic [1:0] EV_WAIT  = 2'd2;
    localparam logic [1:0] EV_SHOW  = 2'd3;

    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_W     = 8'h77;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [31:0] ASCII_ZERO = 32'd48;

    localparam logic [7:0] MODE_PAIR = 8'h02;
    localparam logic [7:0] MODE_QUAD = 8'h04;

    localparam int FRAME_MIN_LEN = 30;
    localparam int TEAM_MIN_LEN  = 19;
    localparam int GATHER_LEN    = 23;
    localparam int MODE_POS      = 5;

    // 24-bit raw time / 10 as multiply by reciprocal and shift
    localparam logic [23:0] RECIP_10    = 24'd13421773;
    localparam int          RECIP_SHIFT = 27;
    localparam int          PART_W      = 21;

    localparam int DIGITS      = 5;
    localparam int OFIFO_DEPTH = 8;
    localparam int OFIFO_AW    = 3;
    localparam int OFIFO_SLACK = 4;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [7:0]  echo_byte;
        logic [31:0] time_value;
        logic        lane;
        logic        last;
    } t_result;

    typedef struct packed {
        logic    vld;
        t_result res;
    } t_push;

    function automatic logic [4:0] digit_off(input logic [2:0] idx);
        case (idx)
            3'd0: digit_off = 5'd0;
            3'd1: digit_off = 5'd2;
            3'd2: digit_off = 5'd3;
            3'd3: digit_off = 5'd5;
            3'd4: digit_off = 5'd6;
            default: digit_off = 5'd0;
        endcase
    endfunction

    function automatic logic [12:0] digit_weight(input logic [2:0] idx);
        case (idx)
            3'd0: digit_weight = 13'd6000;
            3'd1: digit_weight = 13'd1000;
            3'd2: digit_weight = 13'd100;
            3'd3: digit_weight = 13'd10;
            3'd4: digit_weight = 13'd1;
            default: digit_weight = 13'd0;
        endcase
    endfunction

    function automatic t_result mk_res(input logic [1:0] kind, input logic [7:0] b,
                                       input logic [31:0] tv, input logic ln,
                                       input logic lst);
        t_result r;
        r.event_kind = kind;
        r.echo_byte  = b;
        r.time_value = tv;
        r.lane       = ln;
        r.last       = lst;
        return r;
    endfunction

endpackage

FILE: design/tlp_if.sv
// tlp_if: valid/ready channels of the timing line parser
// byte channel in, event channel out; no dependencies
interface tlp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tlp_event_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_kind;
    logic [7:0]  echo_byte;
    logic [31:0] time_value;
    logic        lane;
    logic        last;
    modport source (output valid, output event_kind, output echo_byte, output time_value,
                    output lane, output last, input ready);
    modport sink   (input valid, input event_kind, input echo_byte, input time_value,
                    input lane, input last, output ready);
endinterface

FILE: design/timing_line_parser.sv
// timing_line_parser: top level of the serial timing line decoder
// an ordinary byte's echo word is registered into the result queue as the byte is accepted
// throughput: one byte per cycle; a line end holds the input for the 23-byte
// read sweep of the line memory and then for the decode sequencer (team lines
// longest); a result queue short of room also holds it
// reset: synchronous, active low; line memory reads zero until written
module timing_line_parser #(
    parameter int LINE_DEPTH = 50
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tlp_byte_if.sink     i_rx,
    tlp_event_if.source  o_ev
);
    import tlp_pkg::*;

    localparam int AW = $clog2(LINE_DEPTH);

    t_push           push;
    logic            room;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [7:0]      mem_wdata;
    logic            mem_re;
    logic [AW-1:0]   mem_raddr;
    logic [7:0]      mem_rdata;

    tlp_line_mem #(.DEPTH(LINE_DEPTH), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    tlp_decoder #(.LINE_DEPTH(LINE_DEPTH), .AW(AW)) u_dec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx        (i_rx),
        .i_room      (room),
        .o_push      (push),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    tlp_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_ev    (o_ev)
    );
endmodule

FILE: design/tlp_line_mem.sv
// tlp_line_mem: line buffer memory, one write and one registered read port
// per-entry valid bits make never-written entries read as zero
module tlp_line_mem #(
    parameter int DEPTH = 50,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);
    logic [7:0]       r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [7:0]       r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_vld[i_raddr] ? r_mem[i_raddr] : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: design/tlp_out_fifo.sv
// tlp_out_fifo: result queue between decoder and event channel
// depends on tlp_pkg and tlp_event_if
module tlp_out_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tlp_pkg::t_push  i_push,
    output logic            o_room,
    tlp_event_if.source     o_ev
);
    import tlp_pkg::*;

    t_result                r_buf [OFIFO_DEPTH];
    logic [OFIFO_AW-1:0]    r_wp;
    logic [OFIFO_AW-1:0]    r_rp;
    logic [OFIFO_AW:0]      r_cnt;
    logic                   pop;
    t_result                head;

    assign pop  = o_ev.valid && o_ev.ready;
    assign head = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push.vld) begin
            r_buf[r_wp] <= i_push.res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push.vld) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + {{OFIFO_AW{1'b0}}, i_push.vld} - {{OFIFO_AW{1'b0}}, pop};
        end
    end

    // room for the largest burst one byte can cause
    assign o_room       = r_cnt <= (OFIFO_AW+1)'(OFIFO_DEPTH - OFIFO_SLACK);
    assign o_ev.valid      = r_cnt != '0;
    assign o_ev.event_kind = head.event_kind;
    assign o_ev.echo_byte  = head.echo_byte;
    assign o_ev.time_value = head.time_value;
    assign o_ev.lane       = head.lane;
    assign o_ev.last       = head.last;
endmodule

FILE: design/tlp_decoder.sv
// tlp_decoder: byte intake, fill count and line-end sequencer
// depends on tlp_pkg and tlp_byte_if; drives tlp_line_mem ports
module tlp_decoder #(
    parameter int LINE_DEPTH = 50,
    parameter int AW         = 6
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    tlp_byte_if.sink        i_rx,
    input  logic            i_room,
    output tlp_pkg::t_push  o_push,
    output logic            o_mem_we,
    output logic [AW-1:0]   o_mem_waddr,
    output logic [7:0]      o_mem_wdata,
    output logic            o_mem_re,
    output logic [AW-1:0]   o_mem_raddr,
    input  logic [7:0]      i_mem_rdata
);
    import tlp_pkg::*;

    localparam int FW = $clog2(LINE_DEPTH + 1);
    localparam logic [FW-1:0] DEPTH_F = FW'(LINE_DEPTH);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_GATHER = 4'd1;
    localparam logic [3:0] ST_DIV    = 4'd2;
    localparam logic [3:0] ST_TRK    = 4'd3;
    localparam logic [3:0] ST_CHK01  = 4'd4;
    localparam logic [3:0] ST_SHOW1  = 4'd5;
    localparam logic [3:0] ST_CHK23  = 4'd6;
    localparam logic [3:0] ST_WAITCK = 4'd7;
    localparam logic [3:0] ST_SHORT  = 4'd8;
    localparam logic [3:0] ST_TEAM   = 4'd9;
    localparam logic [3:0] ST_ACC    = 4'd10;
    localparam logic [3:0] ST_ASHOW  = 4'd11;
    localparam logic [3:0] ST_FIN    = 4'd12;

    logic [3:0]        r_state, n_state;
    logic [FW-1:0]     r_fill, n_fill;
    logic [FW-1:0]     r_len, n_len;
    logic [7:0]        r_line [GATHER_LEN];
    logic [7:0]        n_line [GATHER_LEN];
    logic [4:0]        r_rd_idx, n_rd_idx;
    logic              r_rd_pend, n_rd_pend;
    logic [4:0]        r_cap_cnt, n_cap_cnt;
    logic [1:0]        r_part, n_part;
    logic [47:0]       r_prod, n_prod;
    logic [PART_W-1:0] r_pt [4];
    logic [PART_W-1:0] n_pt [4];
    logic [3:0]        r_stop, n_stop;
    logic [1:0]        r_armed, n_armed;
    logic [31:0]       r_shown, n_shown;
    t_result           r_hold, n_hold;
    logic [31:0]       r_acc, n_acc;
    logic [2:0]        r_dig, n_dig;
    logic [4:0]        r_base, n_base;
    logic              r_lane, n_lane;
    logic              r_team_first, n_team_first;

    logic              in_acc;
    logic              is_end;
    logic [FW-1:0]     fill_inc;
    t_result           echo;
    logic [4:0]        pb;
    logic [23:0]       raw;
    logic [PART_W-1:0] t_new;
    logic [7:0]        dbyte;
    logic [31:0]       term;
    logic [31:0]       max01;
    logic [31:0]       max23;
    t_push             push;

    always_comb begin
        i_rx.ready = (r_state == ST_IDLE) && i_room;
    end

    assign in_acc   = i_rx.valid && i_rx.ready;
    assign is_end   = (i_rx.rx_byte == CH_CR) || (i_rx.rx_byte == CH_LF);
    assign fill_inc = r_fill + 1'b1;
    assign echo     = mk_res(EV_ECHO, i_rx.rx_byte, 32'd0, 1'b0, 1'b1);
    assign pb       = 5'd8 + {1'b0, r_part, 2'b00};
    assign raw      = {r_line[pb + 5'd2], r_line[pb + 5'd1], r_line[pb]};
    assign t_new    = r_prod[RECIP_SHIFT +: PART_W];
    assign dbyte    = r_line[r_base + digit_off(r_dig)];
    assign term     = ({24'd0, dbyte} - ASCII_ZERO) * {19'd0, digit_weight(r_dig)};
    assign max01    = {11'd0, (r_pt[0] < r_pt[1]) ? r_pt[1] : r_pt[0]};
    assign max23    = {11'd0, (r_pt[2] < r_pt[3]) ? r_pt[3] : r_pt[2]};

    assign o_mem_we    = in_acc;
    assign o_mem_waddr = r_fill[AW-1:0];
    assign o_mem_wdata = i_rx.rx_byte;
    assign o_mem_re    = (r_state == ST_GATHER) && (r_rd_idx < 5'(GATHER_LEN));
    assign o_mem_raddr = AW'(r_rd_idx);

    always_comb begin
        n_state      = r_state;
        n_fill       = r_fill;
        n_len        = r_len;
        n_line       = r_line;
        n_rd_idx     = r_rd_idx;
        n_rd_pend    = 1'b0;
        n_cap_cnt    = r_cap_cnt;
        n_part       = r_part;
        n_prod       = r_prod;
        n_pt         = r_pt;
        n_stop       = r_stop;
        n_armed      = r_armed;
        n_shown      = r_shown;
        n_hold       = r_hold;
        n_acc        = r_acc;
        n_dig        = r_dig;
        n_base       = r_base;
        n_lane       = r_lane;
        n_team_first = r_team_first;
        push         = '0;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (fill_inc == DEPTH_F) begin
                        // overflow drops the line
                        n_fill   = '0;
                        push.vld = 1'b1;
                        push.res = echo;
                    end else if (is_end && fill_inc != FW'(1)) begin
                        n_len       = fill_inc;
                        n_fill      = '0;
                        n_hold      = echo;
                        n_hold.last = 1'b0;
                        n_rd_idx    = '0;
                        n_cap_cnt   = '0;
                        n_state     = ST_GATHER;
                    end else begin
                        n_fill   = is_end ? '0 : fill_inc;
                        push.vld = 1'b1;
                        push.res = echo;
                    end
                end
            end
            ST_GATHER: begin
                if (o_mem_re) begin
                    n_rd_idx  = r_rd_idx + 5'd1;
                    n_rd_pend = 1'b1;
                end
                if (r_rd_pend) begin
                    for (int i = 0; i < GATHER_LEN - 1; i++) begin
                        n_line[i] = r_line[i+1];
                    end
                    n_line[GATHER_LEN-1] = i_mem_rdata;
                    n_cap_cnt = r_cap_cnt + 5'd1;
                    if (r_cap_cnt == 5'(GATHER_LEN - 1)) begin
                        if (r_len > FW'(FRAME_MIN_LEN)) begin
                            n_part  = 2'd0;
                            n_state = ST_DIV;
                        end else if (r_len < FW'(TEAM_MIN_LEN)) begin
                            n_state = ST_SHORT;
                        end else begin
                            n_state = ST_TEAM;
                        end
                    end
                end
            end
            ST_DIV: begin
                n_prod  = {24'd0, raw} * {24'd0, RECIP_10};
                n_state = ST_TRK;
            end
            ST_TRK: begin
                n_stop[r_part] = (t_new != '0) && (t_new == r_pt[r_part]);
                n_pt[r_part]   = t_new;
                if (r_part == 2'd0 && r_pt[0] == '0 && t_new != '0) begin
                    push.vld = 1'b1;
                    push.res = r_hold;
                    n_hold   = mk_res(EV_START, 8'd0, 32'd0, 1'b0, 1'b0);
                    n_armed  = 2'b11;
                end
                case (r_part)
                    2'd0:    begin n_part = 2'd1; n_state = ST_DIV; end
                    2'd1:    n_state = ST_CHK01;
                    2'd2:    begin n_part = 2'd3; n_state = ST_DIV; end
                    default: n_state = ST_CHK23;
                endcase
            end
            ST_CHK01: begin
                n_state = (r_line[MODE_POS] == MODE_QUAD) ? ST_DIV : ST_WAITCK;
                n_part  = 2'd2;
                if (r_armed[0] && r_stop[0] && r_stop[1]) begin
                    n_shown    = max01;
                    push.vld   = 1'b1;
                    push.res   = r_hold;
                    n_hold     = mk_res(EV_SHOW, 8'd0, max01, 1'b0, 1'b0);
                    n_armed[0] = 1'b0;
                    if (r_line[MODE_POS] == MODE_PAIR) begin
                        n_state = ST_SHOW1;
                    end
                end
            end
            ST_SHOW1: begin
                push.vld   = 1'b1;
                push.res   = r_hold;
                n_hold     = mk_res(EV_SHOW, 8'd0, r_shown, 1'b1, 1'b0);
                n_armed[1] = 1'b0;
                n_state    = ST_FIN;
            end
            ST_CHK23: begin
                if (r_armed[1] && r_stop[2] && r_stop[3]) begin
                    n_shown    = max23;
                    push.vld   = 1'b1;
                    push.res   = r_hold;
                    n_hold     = mk_res(EV_SHOW, 8'd0, max23, 1'b1, 1'b0);
                    n_armed[1] = 1'b0;
                    n_state    = ST_FIN;
                end else begin
                    n_state = ST_WAITCK;
                end
            end
            ST_WAITCK: begin
                if (r_pt[0] == '0 && r_pt[1] == '0 && r_shown != '0) begin
                    n_shown  = '0;
                    push.vld = 1'b1;
                    push.res = r_hold;
                    n_hold   = mk_res(EV_WAIT, 8'd0, 32'd0, 1'b0, 1'b0);
                    n_armed  = 2'b11;
                end
                n_state = ST_FIN;
            end
            ST_SHORT: begin
                n_state = ST_FIN;
                if (r_line[0] == CH_S) begin
                    push.vld = 1'b1;
                    push.res = r_hold;
                    n_hold   = mk_res(EV_START, 8'd0, 32'd0, 1'b0, 1'b0);
                end else if (r_line[0] == CH_W) begin
                    push.vld = 1'b1;
                    push.res = r_hold;
                    n_hold   = mk_res(EV_WAIT, 8'd0, 32'd0, 1'b0, 1'b0);
                end else if (r_line[0] == CH_ONE || r_line[0] == CH_TWO) begin
                    n_base       = 5'd2;
                    n_lane       = r_line[0] == CH_TWO;
                    n_team_first = 1'b0;
                    n_acc        = '0;
                    n_dig        = '0;
                    n_state      = ST_ACC;
                end
            end
            ST_TEAM: begin
                n_lane       = 1'b0;
                n_team_first = 1'b1;
                n_acc        = '0;
                n_dig        = '0;
                if (r_line[0] == CH_HASH) begin
                    n_base  = 5'd1;
                    n_state = ST_ACC;
                end else if (r_line[1] == CH_HASH) begin
                    n_base  = 5'd2;
                    n_state = ST_ACC;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_ACC: begin
                n_acc = r_acc + term;
                n_dig = r_dig + 3'd1;
                if (r_dig == 3'(DIGITS - 1)) begin
                    n_state = ST_ASHOW;
                end
            end
            ST_ASHOW: begin
                n_shown  = r_acc;
                push.vld = 1'b1;
                push.res = r_hold;
                n_hold   = mk_res(EV_SHOW, 8'd0, r_acc, r_lane, 1'b0);
                if (r_team_first) begin
                    // second time of a team line sits nine bytes further
                    n_base       = r_base + 5'd9;
                    n_lane       = 1'b1;
                    n_team_first = 1'b0;
                    n_acc        = '0;
                    n_dig        = '0;
                    n_state      = ST_ACC;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                push.vld      = 1'b1;
                push.res      = r_hold;
                push.res.last = 1'b1;
                n_state       = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_fill    <= '0;
            r_rd_pend <= 1'b0;
            r_armed   <= '0;
            r_shown   <= '0;
            r_pt      <= '{default: '0};
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_rd_pend <= n_rd_pend;
            r_armed   <= n_armed;
            r_shown   <= n_shown;
            r_pt      <= n_pt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len        <= n_len;
        r_line       <= n_line;
        r_rd_idx     <= n_rd_idx;
        r_cap_cnt    <= n_cap_cnt;
        r_part       <= n_part;
        r_prod       <= n_prod;
        r_stop       <= n_stop;
        r_hold       <= n_hold;
        r_acc        <= n_acc;
        r_dig        <= n_dig;
        r_base       <= n_base;
        r_lane       <= n_lane;
        r_team_first <= n_team_first;
    end

    assign o_push = push;

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < DEPTH_F) else $error("fill count out of range");

    a_end_clears_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && is_end) |=> (r_fill == '0)) else $error("line end left fill count");

    a_fin_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) |=> (r_state == ST_IDLE && $past(push.vld)))
        else $error("line decode did not close with a last word");
endmodule

FILE: sim/tlp_checker.sv
// tlp_checker: watches the byte and event channels of the timing line parser,
// predicts every event word from the accepted bytes and compares in order
// depends on tlp_pkg and the channel interfaces in tlp_if
module tlp_checker #(
    parameter int LINE_DEPTH = 50
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    tlp_byte_if   rx,
    tlp_event_if  ev,
    output int    o_fail,
    output int    o_pending,
    output int    o_bytes,
    output int    o_events
);
    import tlp_pkg::*;

    logic [7:0]        line_mem [LINE_DEPTH];
    int unsigned       fill;
    logic [PART_W-1:0] part_t [4];
    bit                armed [2];
    logic [31:0]       shown;
    t_result           want_q [$];
    int                fails, nbytes, nevents;

    assign o_fail    = fails;
    assign o_pending = want_q.size();
    assign o_bytes   = nbytes;
    assign o_events  = nevents;

    function automatic void add_event(logic [1:0] kind, logic [7:0] b, logic [31:0] tv,
                                      logic ln);
        t_result r;
        r.event_kind = kind;
        r.echo_byte  = b;
        r.time_value = tv;
        r.lane       = ln;
        r.last       = 1'b0;
        want_q.push_back(r);
    endfunction

    function automatic logic [31:0] digit_at(int unsigned pos);
        return {24'd0, line_mem[pos % LINE_DEPTH]} - ASCII_ZERO;
    endfunction

    function automatic logic [31:0] text_time(int unsigned p);
        logic [31:0] t;
        t = digit_at(p) * 32'd6000 + digit_at(p + 2) * 32'd1000 + digit_at(p + 3) * 32'd100
            + digit_at(p + 5) * 32'd10 + digit_at(p + 6);
        return t;
    endfunction

    // returns 1 when the part has stopped (same nonzero time twice)
    function automatic bit update_part(int idx, int pos);
        logic [23:0] raw;
        logic [PART_W-1:0] t;
        bit stopped;
        raw = {line_mem[pos+2], line_mem[pos+1], line_mem[pos]};
        t = PART_W'(raw / 24'd10);
        stopped = (t != 0) && (t == part_t[idx]);
        if (idx == 0 && part_t[0] == 0 && t != 0) begin
            add_event(EV_START, 8'd0, 32'd0, 1'b0);
            armed[0] = 1;
            armed[1] = 1;
        end
        part_t[idx] = t;
        return stopped;
    endfunction

    function automatic void decode_frame();
        bit s0, s1, s2, s3;
        s0 = update_part(0, 8);
        s1 = update_part(1, 12);
        if (armed[0] && s0 && s1) begin
            shown = (part_t[0] < part_t[1]) ? 32'(part_t[1]) : 32'(part_t[0]);
            add_event(EV_SHOW, 8'd0, shown, 1'b0);
            armed[0] = 0;
            if (line_mem[MODE_POS] == MODE_PAIR) begin
                add_event(EV_SHOW, 8'd0, shown, 1'b1);
                armed[1] = 0;
                return;
            end
        end
        if (line_mem[MODE_POS] == MODE_QUAD) begin
            s2 = update_part(2, 16);
            s3 = update_part(3, 20);
            if (armed[1] && s2 && s3) begin
                shown = (part_t[2] < part_t[3]) ? 32'(part_t[3]) : 32'(part_t[2]);
                add_event(EV_SHOW, 8'd0, shown, 1'b1);
                armed[1] = 0;
                return;
            end
        end
        if (part_t[0] == 0 && part_t[1] == 0 && shown != 0) begin
            shown = 0;
            add_event(EV_WAIT, 8'd0, 32'd0, 1'b0);
            armed[0] = 1;
            armed[1] = 1;
        end
    endfunction

    function automatic void decode_line();
        logic [7:0] c;
        int unsigned off;
        c = line_mem[0];
        if (fill > FRAME_MIN_LEN) begin
            decode_frame();
        end else if (fill < TEAM_MIN_LEN) begin
            if (c == CH_S) add_event(EV_START, 8'd0, 32'd0, 1'b0);
            else if (c == CH_W) add_event(EV_WAIT, 8'd0, 32'd0, 1'b0);
            else if (c == CH_ONE || c == CH_TWO) begin
                shown = text_time(2);
                add_event(EV_SHOW, 8'd0, shown, c == CH_TWO);
            end
        end else if (line_mem[0] == CH_HASH || line_mem[1] == CH_HASH) begin
            off = (line_mem[0] == CH_HASH) ? 0 : 1;
            shown = text_time(off + 1);
            add_event(EV_SHOW, 8'd0, shown, 1'b0);
            shown = text_time(off + 10);
            add_event(EV_SHOW, 8'd0, shown, 1'b1);
        end
    endfunction

    function automatic void take_byte(logic [7:0] b);
        t_result r;
        add_event(EV_ECHO, b, 32'd0, 1'b0);
        if (fill >= LINE_DEPTH) fill = 0;
        line_mem[fill] = b;
        fill++;
        if (fill > LINE_DEPTH - 1) begin
            fill = 0;  // overflow, line dropped
        end else if (b == CH_CR || b == CH_LF) begin
            if (fill != 1) decode_line();
            fill = 0;
        end
        r = want_q.pop_back();
        r.last = 1'b1;
        want_q.push_back(r);
    endfunction

    always @(posedge i_clk) begin
        t_result w;
        if (!i_rst_n) begin
            foreach (line_mem[k]) line_mem[k] = 8'd0;
            foreach (part_t[k]) part_t[k] = '0;
            armed[0] = 0;
            armed[1] = 0;
            fill = 0;
            shown = 0;
            want_q.delete();
            fails = 0;
            nbytes = 0;
            nevents = 0;
        end else begin
            if (rx.valid && rx.ready) begin
                take_byte(rx.rx_byte);
                nbytes++;
            end
            if (ev.valid && ev.ready) begin
                if (ev.event_kind != EV_ECHO) nevents++;
                if (want_q.size() == 0) begin
                    $error("event word with nothing expected: kind %0d", ev.event_kind);
                    fails++;
                end else begin
                    w = want_q.pop_front();
                    if (ev.event_kind != w.event_kind) begin
                        $error("event_kind expected %0d got %0d", w.event_kind, ev.event_kind);
                        fails++;
                    end
                    if (ev.echo_byte != w.echo_byte) begin
                        $error("echo_byte expected %0d got %0d", w.echo_byte, ev.echo_byte);
                        fails++;
                    end
                    if (ev.time_value != w.time_value) begin
                        $error("time_value expected %0d got %0d", w.time_value, ev.time_value);
                        fails++;
                    end
                    if (ev.lane != w.lane) begin
                        $error("lane expected %0d got %0d", w.lane, ev.lane);
                        fails++;
                    end
                    if (ev.last != w.last) begin
                        $error("last expected %0d got %0d", w.last, ev.last);
                        fails++;
                    end
                end
            end
        end
    end

endmodule

FILE: sim/timing_line_parser_tb.sv
// timing_line_parser_tb: drives serial lines of every kind into the parser
// under several idle mixes and gives the verdict; checking is in tlp_checker
// depends on tlp_pkg, tlp_if, tlp_checker and the block itself
module timing_line_parser_tb;
    import tlp_pkg::*;

    localparam int LINE_DEPTH = 50;
    localparam int CYCLE_LIMIT = 600000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_cnt, pend_cnt, byte_cnt, event_cnt;
    int   idle_pct = 0, stall_pct = 0;
    int   hold_req = 0, hold_seen = 0, hold_left = 0;
    int   cyc = 0;
    logic [7:0] line_buf [$];
    logic [23:0] race_t [4];
    logic [7:0]  race_mode;

    always #1 i_clk = ~i_clk;

    tlp_byte_if  rx ();
    tlp_event_if ev ();

    timing_line_parser #(.LINE_DEPTH(LINE_DEPTH)) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_rx   (rx),
        .o_ev   (ev)
    );

    tlp_checker #(.LINE_DEPTH(LINE_DEPTH)) u_chk (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .rx       (rx),
        .ev       (ev),
        .o_fail   (fail_cnt),
        .o_pending(pend_cnt),
        .o_bytes  (byte_cnt),
        .o_events (event_cnt)
    );

    initial begin
        rx.valid   = 1'b0;
        rx.rx_byte = 8'd0;
        ev.ready   = 1'b0;
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= 400;
            ev.ready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            ev.ready  <= 1'b0;
        end else begin
            ev.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send_byte(logic [7:0] b);
        while ($urandom_range(99) < idle_pct) begin
            rx.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx.valid   <= 1'b1;
        rx.rx_byte <= b;
        @(posedge i_clk);
        while (!rx.ready) @(posedge i_clk);
    endtask

    task automatic send_line();
        foreach (line_buf[k]) send_byte(line_buf[k]);
        line_buf.delete();
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom);
        if (b == CH_CR || b == CH_LF) b = b + 8'd1;
        return b;
    endfunction

    function automatic logic [7:0] line_end();
        return $urandom_range(1) ? CH_CR : CH_LF;
    endfunction

    function automatic logic [7:0] digit_ch();
        return 8'($urandom_range(8'h39, 8'h30));
    endfunction

    // binary lane frame of total length len, line end included
    task automatic make_frame(int len, logic [7:0] mode, logic [23:0] t0, logic [23:0] t1,
                              logic [23:0] t2, logic [23:0] t3);
        logic [23:0] tt [4];
        tt = '{t0, t1, t2, t3};
        for (int k = 0; k < len - 1; k++) line_buf.push_back(plain_byte());
        line_buf[MODE_POS] = mode;
        for (int p = 0; p < 4; p++)
            for (int j = 0; j < 3; j++) begin
                line_buf[8 + 4*p + j] = tt[p][8*j +: 8];
                if (line_buf[8 + 4*p + j] == CH_CR || line_buf[8 + 4*p + j] == CH_LF)
                    line_buf[8 + 4*p + j] += 8'd1;
            end
        line_buf.push_back(line_end());
    endtask

    task automatic make_command(logic [7:0] c, int len);
        line_buf.push_back(c);
        for (int k = 1; k < len - 1; k++)
            line_buf.push_back(($urandom_range(3) != 0) ? digit_ch() : plain_byte());
        line_buf.push_back(line_end());
    endtask

    task automatic make_team(int off, int len);
        for (int k = 0; k < len - 1; k++) line_buf.push_back(digit_ch());
        line_buf[off] = CH_HASH;
        if (off == 1) line_buf[0] = plain_byte();
        line_buf.push_back(line_end());
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        case ($urandom_range(3))
            0: race_mode = MODE_PAIR;
            1, 2: race_mode = MODE_QUAD;
            default: race_mode = plain_byte();
        endcase
        for (int p = 0; p < 4; p++)
            race_t[p] = ($urandom_range(7) == 0) ? 24'hFFFFFF : 24'($urandom_range(200000, 10));

        // no idling: byte extremes, bare end, the start, wait and lane-one commands, first race frame
        idle_pct  = 0;
        stall_pct = 0;
        line_buf = '{8'd0, 8'd255, CH_CR};
        send_line();
        send_byte(CH_LF);
        make_command(CH_S, 3);  send_line();
        make_command(CH_W, 2);  send_line();
        line_buf = '{CH_ONE, 8'h20, 8'h39, 8'h3a, 8'h35, 8'h39, 8'h2e, 8'h39, 8'h39, CH_CR};
        send_line();
        make_frame(31, race_mode, race_t[0], race_t[1], race_t[2], race_t[3]);
        send_line();

        // sender idle: same times again, so the parts stop and shows come out
        idle_pct = 64;
        make_frame(31, race_mode, race_t[0], race_t[1], race_t[2], race_t[3]);
        send_line();
        make_command(CH_TWO, 8); send_line();

        // receiver stalling, with a long hold-off that fills the block
        idle_pct  = 0;
        stall_pct = 64;
        hold_req++;
        make_frame(31, race_mode, 24'd0, 24'd0, 24'd0, 24'd0);
        send_line();

        // both sides idle now and then
        idle_pct  = 12;
        stall_pct = 12;
        make_team($urandom_range(1), 19); send_line();
        make_command(plain_byte(), 4);    send_line();

        rx.valid <= 1'b0;
        while (pend_cnt != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("ran %0d bytes giving %0d start, wait and show events", byte_cnt, event_cnt);
        $display("a lane race through start, show and wait, all short commands, a team line");
        $display("and a stray command, over four idle mixes and one long receiver hold-off");
        if (fail_cnt == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/tlp_pkg.sv
design/tlp_if.sv
design/tlp_line_mem.sv
design/tlp_out_fifo.sv
design/tlp_decoder.sv
design/timing_line_parser.sv
sim/tlp_checker.sv
sim/timing_line_parser_tb.sv
